[design/assert_macros.svh]
// assertion helpers shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CSVT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property that holds in the cycle after a trigger
`define CSVT_ASSERT_NEXT(name, clk, rst_n, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define CSVT_ASSERT(name, clk, rst_n, prop, msg)
`define CSVT_ASSERT_NEXT(name, clk, rst_n, trig, prop, msg)
`endif

`endif

[design/csvt_pkg.sv]
package csvt_pkg;

    // special bytes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] DELIM_RESET  = 8'd44;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;

    // register map
    localparam logic REG_DELIM = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] cell_byte;
        logic       last;
    } t_result;

    // results that one input byte hands to the output buffer
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[design/csvt_decode.sv]
`include "assert_macros.svh"

module csvt_decode
    import csvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    input  logic [7:0] i_delimiter,
    input  logic [1:0] i_space,
    output logic       o_consume,
    output t_push      o_push
);

    logic    r_iq, r_qw, r_rw, r_lc;
    logic    n_iq, n_qw, n_rw, n_lc;
    logic    has_flush, has_cur, iq_eff;
    t_result flush_res, cur_res, res0, res1;
    logic [1:0] cnt;

    // ordinary byte: cell end if it is the delimiter outside quotes, else data
    function automatic t_result f_plain(input logic [7:0] c, input logic [7:0] delim,
                                        input logic iq);
        t_result r;
        r = '0;
        if (c == delim && !iq) begin
            r.kind = KIND_CELL_END;
        end else begin
            r.kind      = KIND_DATA;
            r.cell_byte = c;
        end
        return r;
    endfunction

    // next state and results of the byte in the input register
    always_comb begin
        n_iq      = r_iq;
        n_qw      = r_qw;
        n_rw      = r_rw;
        n_lc      = r_lc;
        has_flush = 1'b0;
        has_cur   = 1'b0;
        flush_res = '0;
        cur_res   = '0;
        iq_eff    = r_qw ? 1'b0 : r_iq;
        if (i_end_of_stream) begin
            has_cur      = r_lc;
            cur_res.kind = KIND_ROW_END;
            n_iq = 1'b0;
            n_qw = 1'b0;
            n_rw = 1'b0;
            n_lc = 1'b0;
        end else if (r_qw && i_data_byte == CH_QUOTE) begin
            // escaped quote inside quotes
            has_cur           = 1'b1;
            cur_res.kind      = KIND_DATA;
            cur_res.cell_byte = CH_QUOTE;
            n_qw = 1'b0;
        end else if (r_rw && i_data_byte == CH_NEWLINE) begin
            // dropped return before newline
            has_cur      = r_lc;
            cur_res.kind = KIND_ROW_END;
            n_iq = 1'b0;
            n_qw = 1'b0;
            n_rw = 1'b0;
            n_lc = 1'b0;
        end else begin
            n_qw = 1'b0;
            n_rw = 1'b0;
            n_iq = iq_eff;
            // a waiting return turns into an ordinary byte
            if (r_rw) begin
                has_flush = 1'b1;
                flush_res = f_plain(CH_RETURN, i_delimiter, iq_eff);
                n_lc      = 1'b1;
            end
            case (i_data_byte)
                CH_NEWLINE: begin
                    has_cur      = r_lc | r_rw;
                    cur_res.kind = KIND_ROW_END;
                    n_iq = 1'b0;
                    n_lc = 1'b0;
                end
                CH_RETURN: begin
                    n_rw = 1'b1;
                end
                CH_QUOTE: begin
                    n_lc = 1'b1;
                    if (iq_eff) begin
                        n_qw = 1'b1;
                    end else begin
                        n_iq = 1'b1;
                    end
                end
                default: begin
                    has_cur = 1'b1;
                    cur_res = f_plain(i_data_byte, i_delimiter, iq_eff);
                    n_lc    = 1'b1;
                end
            endcase
        end
    end

    // pack results in order and mark the final one
    always_comb begin
        cnt  = {1'b0, has_flush} + {1'b0, has_cur};
        res0 = has_flush ? flush_res : cur_res;
        res1 = cur_res;
        res0.last = (cnt == 2'd1);
        res1.last = 1'b1;
    end

    assign o_consume   = i_valid && (cnt <= i_space);
    assign o_push.cnt  = o_consume ? cnt : 2'd0;
    assign o_push.r0   = res0;
    assign o_push.r1   = res1;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq <= 1'b0;
            r_qw <= 1'b0;
            r_rw <= 1'b0;
            r_lc <= 1'b0;
        end else if (o_consume) begin
            r_iq <= n_iq;
            r_qw <= n_qw;
            r_rw <= n_rw;
            r_lc <= n_lc;
        end
    end

    `CSVT_ASSERT(a_one_pending, i_clk, i_rst_n, !(r_qw && r_rw), "quote and return both pending")
    `CSVT_ASSERT(a_qw_in_quotes, i_clk, i_rst_n, !r_qw || r_iq, "pending quote outside quotes")

endmodule

[design/csvt_obuf.sv]
`include "assert_macros.svh"

module csvt_obuf
    import csvt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic [1:0] o_space,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_head
);

    logic [1:0] r_cnt, n_cnt, rem;
    t_result    r_slot0, r_slot1, n_slot0, n_slot1;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign rem     = r_cnt - {1'b0, pop};
    assign o_space = 2'd2 - r_cnt;

    // shift out the head and append new results behind what is left
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        case (rem)
            2'd0: begin
                n_slot0 = i_push.r0;
                n_slot1 = i_push.r1;
            end
            2'd1: begin
                n_slot0 = pop ? r_slot1 : r_slot0;
                n_slot1 = i_push.r0;
            end
            default: begin
                n_slot0 = r_slot0;
                n_slot1 = r_slot1;
            end
        endcase
        n_cnt = rem + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot0;

    `CSVT_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "result buffer overfilled")
    `CSVT_ASSERT(a_push_fits, i_clk, i_rst_n, ({1'b0, r_cnt} + {1'b0, i_push.cnt}) <= 3'd2, "push exceeds space")
    `CSVT_ASSERT(a_row_end_last, i_clk, i_rst_n, !(o_valid && r_slot0.kind == KIND_ROW_END) || r_slot0.last, "row end not last")
    `CSVT_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid, "stalled beat dropped")

endmodule

[design/csv_quoted_field_tokenizer_core.sv]
// CSV tokenizer with quote escapes.
// Input channel (i_valid / o_stall): one beat per raw file byte, or one
// end-of-stream beat (i_end_of_stream high, byte ignored) that closes a
// final line without newline. Output channel (o_valid / i_stall): one beat
// per result: o_kind 0 = cell byte in o_cell_byte, 1 = cell end, 2 = last
// cell end and row end; o_last marks the final result of an input byte.
// Delimiter register at APB address 0, reset to comma.
// A byte is held in the input register and decoded into the two-entry
// result buffer, whose head drives the output; a full buffer holds it back.
// Throughput: one byte per cycle while the receiver does not stall and
// each byte gives at most one result; a byte that gives two results (a
// pending carriage return that turns into data, then the new byte) waits
// for the result buffer to empty, and a following byte with a result waits
// while the second result drains. The two result slots set this limit.
// Reset clears the parser state, the buffers and sets the delimiter to comma.
// While the receiver stalls, results stay in the buffer, the input register
// holds its byte and o_stall rises once the buffer cannot take its results.
module csv_quoted_field_tokenizer_core
    import csvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input bytes
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    // results
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_cell_byte,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_delim;
    logic       r_in_valid, r_in_eos;
    logic [7:0] r_in_byte;
    logic       consume, in_take;
    logic [1:0] space;
    t_push      push;
    t_result    head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DELIM) ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DELIM) begin
            r_delim <= pwdata[7:0];
        end
    end

    // input register
    assign o_stall = r_in_valid && !consume;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    csvt_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_data_byte     (r_in_byte),
        .i_end_of_stream (r_in_eos),
        .i_delimiter     (r_delim),
        .i_space         (space),
        .o_consume       (consume),
        .o_push          (push)
    );

    csvt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_kind      = head.kind;
    assign o_cell_byte = head.cell_byte;
    assign o_last      = head.last;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
    import csvt_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ROW_ITEMS     = 140;
    localparam logic [7:0] DELIM_SWEEP [9] = '{8'h3B, 8'h00, 8'hFF, CH_QUOTE, CH_NEWLINE,
                                                CH_RETURN, 8'h09, 8'h7C, DELIM_RESET};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_stream;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_cell_byte;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // tokenizer state as the bench tracks it
    logic [7:0] delim_now;
    bit         quoted_now;
    bit         quote_held;
    bit         return_held;
    bit         line_open;

    t_result    tokens_due[$];
    int         mismatches;
    int         cycles;
    int         stall_left;
    int         items_sent;
    bit         calm;

    csv_quoted_field_tokenizer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_cell_byte     (o_cell_byte),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int seen);
        $display("mismatch at cycle %0d: %s, expected %0h, got %0h", cycles, what, want, seen);
        mismatches++;
    endtask

    // wait drawn per item or result; none at all in calm phases
    function automatic int draw_wait();
        if (calm)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 18);
        return 0;
    endfunction

    // token prediction
    function automatic void push_token(input logic [1:0] kind, input logic [7:0] b);
        t_result r;
        r.kind      = kind;
        r.cell_byte = b;
        r.last      = 1'b0;
        tokens_due.insert(tokens_due.size(), r);
    endfunction

    function automatic void plain_token(input logic [7:0] b);
        line_open = 1'b1;
        if (b == delim_now && !quoted_now)
            push_token(KIND_CELL_END, 8'h00);
        else
            push_token(KIND_DATA, b);
    endfunction

    function automatic void close_row();
        if (line_open)
            push_token(KIND_ROW_END, 8'h00);
        quoted_now  = 1'b0;
        quote_held  = 1'b0;
        return_held = 1'b0;
        line_open   = 1'b0;
    endfunction

    function automatic void predict_tokens(input logic [7:0] b, input logic eos);
        int  prior_cnt;
        bit  handled;
        prior_cnt = tokens_due.size();
        handled   = 1'b0;
        if (eos) begin
            close_row();
            handled = 1'b1;
        end
        // a held quote is either an escaped quote or the end of quoted mode
        if (!handled && quote_held) begin
            quote_held = 1'b0;
            if (b == CH_QUOTE) begin
                push_token(KIND_DATA, CH_QUOTE);
                handled = 1'b1;
            end else begin
                quoted_now = 1'b0;
            end
        end
        // a held return is dropped before a newline, else counts as a byte
        if (!handled && return_held) begin
            return_held = 1'b0;
            if (b == CH_NEWLINE) begin
                close_row();
                handled = 1'b1;
            end else begin
                plain_token(CH_RETURN);
            end
        end
        if (!handled) begin
            if (b == CH_NEWLINE) begin
                close_row();
            end else if (b == CH_RETURN) begin
                return_held = 1'b1;
            end else if (b == CH_QUOTE) begin
                line_open = 1'b1;
                if (quoted_now)
                    quote_held = 1'b1;
                else
                    quoted_now = 1'b1;
            end else begin
                plain_token(b);
            end
        end
        if (tokens_due.size() > prior_cnt)
            tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    // result checking
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tokens_due.size() == 0) begin
                report_mismatch("result with none due, kind", 0, o_kind);
            end else begin
                want = tokens_due.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", want.kind, o_kind);
                if (o_cell_byte !== want.cell_byte)
                    report_mismatch("cell byte", want.cell_byte, o_cell_byte);
                if (o_last !== want.last)
                    report_mismatch("last flag", want.last, o_last);
            end
            stall_left = draw_wait();
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // one input beat; valid stays high into the next beat when there is no gap
    task automatic send_beat(input logic [7:0] b, input logic eos);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_stall);
        predict_tokens(b, eos);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_beat(s[k], 1'b0);
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // stop sending until every due token has arrived and the pipe is empty
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register access
    task automatic check_delimiter();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_DELIM, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== delim_now)
            report_mismatch("delimiter readback", delim_now, prdata[7:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_delimiter(input logic [7:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DELIM, 2'b00};
        pwdata  <= {24'h0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        delim_now = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_delimiter();
    endtask

    // random content
    function automatic logic [7:0] plain_body();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_RETURN || b == CH_NEWLINE || b == delim_now)
            b = 8'h61 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    function automatic logic [7:0] quoted_body();
        case ($urandom_range(0, 9))
            0: return CH_QUOTE;
            1: return delim_now;
            2: return CH_RETURN;
            default: return plain_body();
        endcase
    endfunction

    // well-formed row with random cells, some quoted
    task automatic send_random_row();
        int         cells;
        int         len;
        bit         quoted;
        logic [7:0] b;
        cells = $urandom_range(1, 4);
        for (int c = 0; c < cells; c++) begin
            if (c > 0)
                send_beat(delim_now, 1'b0);
            quoted = ($urandom_range(0, 2) == 0);
            if (quoted)
                send_beat(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) begin
                b = quoted ? quoted_body() : plain_body();
                send_beat(b, 1'b0);
                if (quoted && b == CH_QUOTE)
                    send_beat(CH_QUOTE, 1'b0);
            end
            if (quoted)
                send_beat(CH_QUOTE, 1'b0);
        end
        case ($urandom_range(0, 5))
            0, 1: send_beat(CH_NEWLINE, 1'b0);
            2: send_text("\r\n");
            3: send_end();
            4: send_text("\n\n");
            default: send_text("\r\n\r\n");
        endcase
    endtask

    // broken rows and stray special bytes
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0: send_beat(CH_QUOTE, 1'b0);
                1: send_beat(CH_RETURN, 1'b0);
                2: send_beat(CH_NEWLINE, 1'b0);
                3: send_beat(delim_now, 1'b0);
                default: send_beat(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            send_end();
    endtask

    // register default after reset
    task automatic test_register_reset();
        check_delimiter();
    endtask

    // quoting with the default comma
    task automatic test_quoting();
        send_text("a,\"x\"\"y\"\r\n");
        // newline inside quotes still ends the row
        send_text("\"q\n");
        // closing quote followed by plain byte, then end of stream
        send_text("\"p\"z");
        send_end();
    endtask

    // an empty line, carriage return as data, byte extremes
    task automatic test_line_ends();
        send_beat(CH_NEWLINE, 1'b0);
        send_beat(CH_RETURN, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CH_RETURN, 1'b0);
        send_end();
    endtask

    // sender holds off mid-row until the output is empty
    task automatic test_drain_pause();
        send_text("\"ab");
        wait_drained();
        send_text("\"\",c\r");
        wait_drained();
        send_beat(CH_NEWLINE, 1'b0);
    endtask

    // random rows under each delimiter setting
    task automatic test_delimiters();
        int start_cnt;
        foreach (DELIM_SWEEP[d]) begin
            wait_drained();
            write_delimiter(DELIM_SWEEP[d]);
            calm = (d % 3 == 2);
            start_cnt = items_sent;
            while (items_sent - start_cnt < ROW_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_random_row();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = 8'h00;
        i_end_of_stream = 1'b0;
        i_stall         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'h0;
        delim_now       = DELIM_RESET;
        quoted_now      = 1'b0;
        quote_held      = 1'b0;
        return_held     = 1'b0;
        line_open       = 1'b0;
        mismatches      = 0;
        stall_left      = 0;
        items_sent      = 0;
        calm            = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_quoting();
        test_line_ends();
        test_drain_pause();
        test_delimiters();
        wait_drained();

        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
